/* rtl/pwmpwd_pkg.sv */
package pwmpwd_pkg;

    localparam int WIDTH_W    = 16;
    localparam int BITS_W     = 6;
    localparam int SERIAL_W   = 20;
    localparam int BUTTON_W   = 4;
    localparam int PACKET_W   = 40;
    localparam int PIDX_W     = 4;
    localparam int MIN_PULSES = 14;
    localparam int TDATA_IN_W = 16;
    localparam int TDATA_OUT_W = 72;
    localparam int ADDR_W     = 5;

    localparam logic [WIDTH_W-1:0] ZERO_LO_RST     = 16'd200;
    localparam logic [WIDTH_W-1:0] ZERO_HI_RST     = 16'd720;
    localparam logic [WIDTH_W-1:0] ONE_LO_RST      = 16'd600;
    localparam logic [WIDTH_W-1:0] ONE_HI_RST      = 16'd2160;
    localparam logic [WIDTH_W-1:0] FLOAT_ABOVE_RST = 16'd2800;
    localparam logic [WIDTH_W-1:0] SYNC_ABOVE_RST  = 16'd3600;
    localparam logic [BITS_W-1:0]  MIN_BITS_RST    = 6'd20;
    localparam logic [BITS_W-1:0]  MAX_BITS_RST    = 6'd40;

    typedef enum logic [2:0] {
        REG_ZERO_LO     = 3'd0,
        REG_ZERO_HI     = 3'd1,
        REG_ONE_LO      = 3'd2,
        REG_ONE_HI      = 3'd3,
        REG_FLOAT_ABOVE = 3'd4,
        REG_SYNC_ABOVE  = 3'd5,
        REG_MIN_BITS    = 3'd6,
        REG_MAX_BITS    = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] zero_lo;
        logic [WIDTH_W-1:0] zero_hi;
        logic [WIDTH_W-1:0] one_lo;
        logic [WIDTH_W-1:0] one_hi;
        logic [WIDTH_W-1:0] float_above;
        logic [WIDTH_W-1:0] sync_above;
        logic [BITS_W-1:0]  min_bits;
        logic [BITS_W-1:0]  max_bits;
    } cfg_t;

    typedef struct packed {
        logic [BITS_W-1:0]   bit_total;
        logic [PACKET_W-1:0] packet_bits;
        logic [BUTTON_W-1:0] button_code;
        logic [SERIAL_W-1:0] serial_number;
        logic                packet_valid;
    } result_t;

endpackage

/* rtl/pwmpwd_core.sv */
module pwmpwd_core
    import pwmpwd_pkg::*;
#(
    parameter int SYNC_WINDOW = 6,
    parameter int DATA_BITS   = 40
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               pulse_valid,
    input  logic [WIDTH_W-1:0] pulse_width,
    input  logic               last_pulse,
    input  cfg_t               cfg,
    output result_t            res,
    output logic               res_valid
);

    localparam int CW   = $clog2(DATA_BITS + 1);
    localparam int CMPW = (CW > BITS_W) ? CW : BITS_W;
    localparam logic [CMPW-1:0]   DATA_BITS_C  = CMPW'(DATA_BITS);
    localparam logic [PIDX_W-1:0] SYNC_W_C     = PIDX_W'(SYNC_WINDOW);
    localparam logic [PIDX_W-1:0] MIN_PULSES_C = PIDX_W'(MIN_PULSES);

    logic [DATA_BITS-1:0] shift_reg, shift_next;
    logic [CW-1:0]        bits_reg, bits_next;
    logic [PIDX_W-1:0]    pidx_reg, pidx_next;
    logic                 sync_reg, sync_next;
    logic                 stop_reg, stop_next;

    logic [CMPW-1:0]      max_ext, min_ext, limit, bits_ext, bits_inc_ext, bits_out_ext;
    logic [CW-1:0]        bits_inc;
    logic                 sync_hit, is_short, is_long, is_float, bit_ok;
    logic [PACKET_W+DATA_BITS-1:0] pkt_ext;
    logic [PACKET_W-1:0]  pkt;

    always_comb begin
        max_ext      = CMPW'(cfg.max_bits);
        min_ext      = CMPW'(cfg.min_bits);
        limit        = (max_ext < DATA_BITS_C) ? max_ext : DATA_BITS_C;
        bits_ext     = CMPW'(bits_reg);
        bits_inc     = bits_reg + CW'(1);
        bits_inc_ext = CMPW'(bits_inc);

        sync_hit = (pidx_reg < SYNC_W_C) && !sync_reg && (pulse_width > cfg.sync_above);
        is_short = (pulse_width >= cfg.zero_lo) && (pulse_width <= cfg.zero_hi);
        is_long  = (pulse_width >= cfg.one_lo) && (pulse_width <= cfg.one_hi);
        is_float = pulse_width > cfg.float_above;
        bit_ok   = is_short || is_long || is_float;

        shift_next = shift_reg;
        bits_next  = bits_reg;
        sync_next  = sync_reg;
        stop_next  = stop_reg;

        if (sync_hit) begin
            sync_next  = 1'b1;
            shift_next = '0;
            bits_next  = '0;
            stop_next  = 1'b0;
        end else if (!stop_reg) begin
            if (bits_ext >= limit || !bit_ok) begin
                stop_next = 1'b1;
            end else begin
                shift_next = {shift_reg[DATA_BITS-2:0], !is_short};
                bits_next  = bits_inc;
                if (bits_inc_ext >= limit) begin
                    stop_next = 1'b1;
                end
            end
        end

        pidx_next = (pidx_reg < MIN_PULSES_C) ? pidx_reg + PIDX_W'(1) : pidx_reg;

        pkt_ext      = {{PACKET_W{1'b0}}, shift_next};
        pkt          = pkt_ext[PACKET_W-1:0];
        bits_out_ext = CMPW'(bits_next);

        res.packet_valid  = (pidx_next >= MIN_PULSES_C) && (bits_out_ext >= min_ext);
        res.serial_number = pkt[SERIAL_W-1:0];
        res.button_code   = pkt[SERIAL_W+BUTTON_W-1:SERIAL_W];
        res.packet_bits   = pkt;
        res.bit_total     = bits_out_ext[BITS_W-1:0];
        res_valid         = pulse_valid && last_pulse;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || res_valid) begin
            shift_reg <= '0;
            bits_reg  <= '0;
            pidx_reg  <= '0;
            sync_reg  <= 1'b0;
            stop_reg  <= 1'b0;
        end else if (pulse_valid) begin
            shift_reg <= shift_next;
            bits_reg  <= bits_next;
            pidx_reg  <= pidx_next;
            sync_reg  <= sync_next;
            stop_reg  <= stop_next;
        end
    end

endmodule

/* rtl/pwm_pulse_width_decoder_unit.sv */
// a burst's result is registered into the output stage, or into its skid entry, on the last-pulse transfer
// throughput: one pulse per cycle while s_tready is high, set by the classify and shift step
// a two-entry output stage keeps s_tready high while one result waits on m_tready
// reset: synchronous on aresetn low; registers return to defaults, burst state clears
module pwm_pulse_width_decoder_unit
    import pwmpwd_pkg::*;
#(
    parameter int SYNC_WINDOW = 6,
    parameter int DATA_BITS   = 40
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // pulse_width[15:0]
    input  logic                   s_tlast,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // packet_valid, serial_number[20], button_code[4], packet_bits[40], bit_total[6], pad
    output logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    cfg_t     cfg_reg;
    result_t  core_res, out_reg, skid_reg;
    logic     core_res_valid, out_valid_reg, skid_valid_reg;
    logic     s_xfer, m_xfer, cfg_wr;
    reg_idx_t cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = reg_idx_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.zero_lo     <= ZERO_LO_RST;
            cfg_reg.zero_hi     <= ZERO_HI_RST;
            cfg_reg.one_lo      <= ONE_LO_RST;
            cfg_reg.one_hi      <= ONE_HI_RST;
            cfg_reg.float_above <= FLOAT_ABOVE_RST;
            cfg_reg.sync_above  <= SYNC_ABOVE_RST;
            cfg_reg.min_bits    <= MIN_BITS_RST;
            cfg_reg.max_bits    <= MAX_BITS_RST;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ZERO_LO:     cfg_reg.zero_lo     <= pwdata[WIDTH_W-1:0];
                REG_ZERO_HI:     cfg_reg.zero_hi     <= pwdata[WIDTH_W-1:0];
                REG_ONE_LO:      cfg_reg.one_lo      <= pwdata[WIDTH_W-1:0];
                REG_ONE_HI:      cfg_reg.one_hi      <= pwdata[WIDTH_W-1:0];
                REG_FLOAT_ABOVE: cfg_reg.float_above <= pwdata[WIDTH_W-1:0];
                REG_SYNC_ABOVE:  cfg_reg.sync_above  <= pwdata[WIDTH_W-1:0];
                REG_MIN_BITS:    cfg_reg.min_bits    <= pwdata[BITS_W-1:0];
                REG_MAX_BITS:    cfg_reg.max_bits    <= pwdata[BITS_W-1:0];
                default:         cfg_reg             <= cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ZERO_LO:     prdata = 32'(cfg_reg.zero_lo);
            REG_ZERO_HI:     prdata = 32'(cfg_reg.zero_hi);
            REG_ONE_LO:      prdata = 32'(cfg_reg.one_lo);
            REG_ONE_HI:      prdata = 32'(cfg_reg.one_hi);
            REG_FLOAT_ABOVE: prdata = 32'(cfg_reg.float_above);
            REG_SYNC_ABOVE:  prdata = 32'(cfg_reg.sync_above);
            REG_MIN_BITS:    prdata = 32'(cfg_reg.min_bits);
            REG_MAX_BITS:    prdata = 32'(cfg_reg.max_bits);
            default:         prdata = '0;
        endcase
    end

    assign s_tready = !skid_valid_reg;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_xfer   = m_tvalid && m_tready;

    pwmpwd_core #(
        .SYNC_WINDOW (SYNC_WINDOW),
        .DATA_BITS   (DATA_BITS)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pulse_valid (s_xfer),
        .pulse_width (s_tdata[WIDTH_W-1:0]),
        .last_pulse  (s_tlast),
        .cfg         (cfg_reg),
        .res         (core_res),
        .res_valid   (core_res_valid)
    );

    // output register with skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_xfer) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= core_res_valid;
            end else begin
                out_valid_reg  <= core_res_valid;
            end
        end else if (core_res_valid) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || m_xfer) begin
            out_reg <= skid_valid_reg ? skid_reg : core_res;
            if (core_res_valid) begin
                skid_reg <= core_res;
            end
        end else if (core_res_valid) begin
            skid_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_reg};

endmodule

/* rtl/pwmpwd_checker.sv */
module pwmpwd_checker
    import pwmpwd_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic                   s_tlast,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [TDATA_OUT_W-1:0] m_tdata
);

    // nothing shown on the result side straight after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a new result only follows a last-pulse transfer
    a_rise_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready && s_tlast))
        else $error("result without last pulse");

    // input back-pressure only while a result is pending
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
        else $error("input stalled with no pending result");

    // a result transfer frees the input side
    a_ready_back: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready |=> s_tready)
        else $error("input still stalled after result transfer");

endmodule

bind pwm_pulse_width_decoder_unit pwmpwd_checker u_checker (.*);

/* dv/pwm_decode_checker.sv */
module pwm_decode_checker
    import pwmpwd_pkg::*;
#(
    parameter int SYNC_WINDOW = 6,
    parameter int DATA_BITS   = 40
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    input  logic                   s_tready,
    input  logic [TDATA_IN_W-1:0]  s_tdata,   // pulse_width[15:0]
    input  logic                   s_tlast,
    input  logic                   m_tvalid,
    input  logic                   m_tready,
    // packet_valid, serial_number[20], button_code[4], packet_bits[40], bit_total[6], pad
    input  logic [TDATA_OUT_W-1:0] m_tdata,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic                   pready,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [31:0]            pwdata,
    output int                     pending,
    output int                     mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    cfg_t                settings;
    logic [PACKET_W-1:0] burst_bits;
    logic [BITS_W-1:0]   burst_nbits;
    logic [PIDX_W-1:0]   burst_pulses;
    logic                sync_seen;
    logic                decode_halted;
    result_t             packets_due[$];

    initial mismatch_count = 0;
    initial pending = 0;

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("%0t ns %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic clear_burst();
        burst_bits    = '0;
        burst_nbits   = '0;
        burst_pulses  = '0;
        sync_seen     = 1'b0;
        decode_halted = 1'b0;
    endtask

    task automatic decode_pulse(input logic [WIDTH_W-1:0] w, input logic last);
        int      limit;
        logic    bit_val;
        logic    bit_ok;
        result_t want;
        limit  = (settings.max_bits < DATA_BITS) ? int'(settings.max_bits) : DATA_BITS;
        bit_ok = 1'b1;
        bit_val = 1'b0;
        if (burst_pulses < SYNC_WINDOW && !sync_seen && w > settings.sync_above) begin
            sync_seen     = 1'b1;
            burst_bits    = '0;
            burst_nbits   = '0;
            decode_halted = 1'b0;
        end else if (!decode_halted) begin
            if (burst_nbits >= limit) begin
                decode_halted = 1'b1;
            end else begin
                // short wins over long, long over float
                if (w >= settings.zero_lo && w <= settings.zero_hi) begin
                    bit_val = 1'b0;
                end else if (w >= settings.one_lo && w <= settings.one_hi) begin
                    bit_val = 1'b1;
                end else if (w > settings.float_above) begin
                    bit_val = 1'b1;
                end else begin
                    bit_ok = 1'b0;
                end
                if (!bit_ok) begin
                    decode_halted = 1'b1;
                end else begin
                    burst_bits  = {burst_bits[PACKET_W-2:0], bit_val};
                    burst_nbits = burst_nbits + BITS_W'(1);
                    if (burst_nbits >= limit) decode_halted = 1'b1;
                end
            end
        end
        if (burst_pulses < MIN_PULSES) burst_pulses = burst_pulses + PIDX_W'(1);
        if (last) begin
            want.packet_valid  = (burst_pulses >= MIN_PULSES) &&
                                 (burst_nbits >= settings.min_bits);
            want.serial_number = burst_bits[SERIAL_W-1:0];
            want.button_code   = burst_bits[SERIAL_W+BUTTON_W-1:SERIAL_W];
            want.packet_bits   = burst_bits;
            want.bit_total     = burst_nbits;
            packets_due.push_back(want);
            clear_burst();
        end
    endtask

    task automatic check_packet(input result_t got);
        result_t want;
        if (packets_due.size() == 0) begin
            flag_mismatch("packet with none predicted", 64'(got.packet_bits), 64'd0);
        end else begin
            want = packets_due.pop_front();
            if (got.packet_valid !== want.packet_valid)
                flag_mismatch("packet_valid", 64'(got.packet_valid),
                              64'(want.packet_valid));
            if (got.serial_number !== want.serial_number)
                flag_mismatch("serial_number", 64'(got.serial_number),
                              64'(want.serial_number));
            if (got.button_code !== want.button_code)
                flag_mismatch("button_code", 64'(got.button_code), 64'(want.button_code));
            if (got.packet_bits !== want.packet_bits)
                flag_mismatch("packet_bits", 64'(got.packet_bits), 64'(want.packet_bits));
            if (got.bit_total !== want.bit_total)
                flag_mismatch("bit_total", 64'(got.bit_total), 64'(want.bit_total));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            settings.zero_lo     = ZERO_LO_RST;
            settings.zero_hi     = ZERO_HI_RST;
            settings.one_lo      = ONE_LO_RST;
            settings.one_hi      = ONE_HI_RST;
            settings.float_above = FLOAT_ABOVE_RST;
            settings.sync_above  = SYNC_ABOVE_RST;
            settings.min_bits    = MIN_BITS_RST;
            settings.max_bits    = MAX_BITS_RST;
            clear_burst();
            packets_due.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[ADDR_W-1:2]))
                    REG_ZERO_LO:     settings.zero_lo     = pwdata[WIDTH_W-1:0];
                    REG_ZERO_HI:     settings.zero_hi     = pwdata[WIDTH_W-1:0];
                    REG_ONE_LO:      settings.one_lo      = pwdata[WIDTH_W-1:0];
                    REG_ONE_HI:      settings.one_hi      = pwdata[WIDTH_W-1:0];
                    REG_FLOAT_ABOVE: settings.float_above = pwdata[WIDTH_W-1:0];
                    REG_SYNC_ABOVE:  settings.sync_above  = pwdata[WIDTH_W-1:0];
                    REG_MIN_BITS:    settings.min_bits    = pwdata[BITS_W-1:0];
                    REG_MAX_BITS:    settings.max_bits    = pwdata[BITS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) decode_pulse(s_tdata[WIDTH_W-1:0], s_tlast);
            if (m_tvalid && m_tready) check_packet(result_t'(m_tdata[$bits(result_t)-1:0]));
        end
        pending <= packets_due.size();
    end

endmodule

/* dv/pwm_pulse_width_decoder_unit_tb.sv */
module pwm_pulse_width_decoder_unit_tb;
    import pwmpwd_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT    = 200000;
    localparam int HOLD_CYCLES    = 300;
    localparam int PHASE_PULSES   = 100;
    localparam int PHASES         = 8;

    typedef enum int {PK_SHORT, PK_LONG, PK_FLOAT, PK_SYNC, PK_ANY} pulse_kind_t;

    logic                   aclk;
    logic                   aresetn  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [TDATA_IN_W-1:0]  s_tdata  = '0;
    logic                   s_tlast  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [ADDR_W-1:0]      paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    int   pending;
    int   mismatch_count;
    int   cycle_count = 0;
    int   pulses_sent = 0;
    bit   tx_fast     = 1'b0;
    bit   rx_fast     = 1'b0;
    bit   rx_hold_req = 1'b0;
    cfg_t cur;

    pwm_pulse_width_decoder_unit u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pwm_decode_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pending        (pending),
        .mismatch_count (mismatch_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("pwm_pulse_width_decoder_unit: mismatch");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial begin
        int gap;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            gap = rx_fast ? 0 : $urandom_range(9, 0);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    task automatic reg_write(input reg_idx_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic apply_settings(input cfg_t c);
        reg_write(REG_ZERO_LO,     32'(c.zero_lo));
        reg_write(REG_ZERO_HI,     32'(c.zero_hi));
        reg_write(REG_ONE_LO,      32'(c.one_lo));
        reg_write(REG_ONE_HI,      32'(c.one_hi));
        reg_write(REG_FLOAT_ABOVE, 32'(c.float_above));
        reg_write(REG_SYNC_ABOVE,  32'(c.sync_above));
        reg_write(REG_MIN_BITS,    32'(c.min_bits));
        reg_write(REG_MAX_BITS,    32'(c.max_bits));
        cur = c;
    endtask

    function automatic cfg_t default_settings();
        cfg_t c;
        c.zero_lo     = ZERO_LO_RST;
        c.zero_hi     = ZERO_HI_RST;
        c.one_lo      = ONE_LO_RST;
        c.one_hi      = ONE_HI_RST;
        c.float_above = FLOAT_ABOVE_RST;
        c.sync_above  = SYNC_ABOVE_RST;
        c.min_bits    = MIN_BITS_RST;
        c.max_bits    = MAX_BITS_RST;
        return c;
    endfunction

    function automatic cfg_t settings_for(input int phase);
        cfg_t c;
        c = default_settings();
        case (phase)
            1: begin
                // extreme settings: width 0 is short, all else long
                c.zero_lo = 16'd0;  c.zero_hi = 16'd0;
                c.one_lo  = 16'd0;  c.one_hi  = 16'hFFFF;
                c.float_above = 16'hFFFF; c.sync_above = 16'd0;
                c.min_bits = 6'd0;    c.max_bits = 6'd1;
            end
            2: begin
                // no sync possible, long range inverted, max_bits above the data width
                c.zero_lo = 16'hFFFF; c.zero_hi = 16'hFFFF;
                c.one_lo  = 16'hFFFF; c.one_hi  = 16'd0;
                c.float_above = 16'd0;  c.sync_above = 16'hFFFF;
                c.min_bits = 6'd40;     c.max_bits = 6'd63;
            end
            3: begin
                c.min_bits = 6'd0;
                c.max_bits = 6'd0;
            end
            4: begin
                c.zero_lo = 16'd720;  c.zero_hi = 16'd200;
                c.one_lo  = 16'd2160; c.one_hi  = 16'd600;
                c.float_above = 16'd1000;
                c.min_bits = 6'd63;     c.max_bits = 6'd30;
            end
            5: begin
                c.min_bits = 6'd35;
                c.max_bits = 6'd24;
            end
            default: begin
                c.zero_lo     = WIDTH_W'($urandom_range(1500, 0));
                c.zero_hi     = c.zero_lo + WIDTH_W'($urandom_range(1500, 0));
                c.one_lo      = WIDTH_W'($urandom_range(3000, 0));
                c.one_hi      = c.one_lo + WIDTH_W'($urandom_range(4000, 0));
                c.float_above = WIDTH_W'($urandom_range(12000, 0));
                c.sync_above  = c.float_above + WIDTH_W'($urandom_range(30000, 0));
                c.min_bits    = BITS_W'($urandom_range(40, 0));
                c.max_bits    = BITS_W'($urandom_range(40, 1));
            end
        endcase
        return c;
    endfunction

    function automatic logic [WIDTH_W-1:0] pick_between(input int unsigned lo,
                                                        input int unsigned hi);
        if (lo <= hi) return WIDTH_W'($urandom_range(hi, lo));
        return WIDTH_W'($urandom_range(65535, 0));
    endfunction

    function automatic logic [WIDTH_W-1:0] pick_width(input pulse_kind_t kind);
        case (kind)
            PK_SHORT: return pick_between(32'(cur.zero_lo), 32'(cur.zero_hi));
            PK_LONG:  return pick_between(32'(cur.one_lo), 32'(cur.one_hi));
            PK_FLOAT: return pick_between(32'(cur.float_above) + 32'd1, 32'd65535);
            PK_SYNC:  return pick_between(32'(cur.sync_above) + 32'd1, 32'd65535);
            default: begin
                case ($urandom_range(7, 0))
                    0:       return 16'h0000;
                    1:       return 16'hFFFF;
                    default: return WIDTH_W'($urandom);
                endcase
            end
        endcase
    endfunction

    task automatic send_pulse(input logic [WIDTH_W-1:0] w, input logic last);
        int gap;
        gap = tx_fast ? 0 : $urandom_range(9, 0);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        s_tlast  <= last;
        do @(posedge aclk); while (!(s_tvalid && s_tready));
        pulses_sent++;
    endtask

    task automatic send_burst();
        int          n_pre;
        int          n_data;
        int          pick;
        pulse_kind_t kind;
        if ($urandom_range(3, 0) == 0) begin
            n_data = $urandom_range(20, 1);
            for (int i = 0; i < n_data; i++) send_pulse(pick_width(PK_ANY), i == n_data - 1);
        end else begin
            // sync mostly inside the window, sometimes too late or missing
            n_pre = ($urandom_range(7, 0) == 0) ? $urandom_range(8, 6) : $urandom_range(5, 0);
            for (int i = 0; i < n_pre; i++)
                send_pulse(pick_width(pulse_kind_t'($urandom_range(4, 0))), 1'b0);
            if ($urandom_range(9, 0) != 0) send_pulse(pick_width(PK_SYNC), 1'b0);
            n_data = ($urandom_range(4, 0) == 0) ? $urandom_range(45, 30)
                                                : $urandom_range(28, 10);
            for (int i = 0; i < n_data; i++) begin
                pick = $urandom_range(9, 0);
                if ($urandom_range(29, 0) == 0) kind = PK_ANY;
                else if (pick < 4)              kind = PK_SHORT;
                else if (pick < 8)              kind = PK_LONG;
                else if (pick < 9)              kind = PK_FLOAT;
                else                            kind = PK_SYNC;
                send_pulse(pick_width(kind), i == n_data - 1);
            end
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        repeat (2) @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    initial begin
        int phase_end;
        cur = default_settings();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                apply_settings(settings_for(p));
            end
            tx_fast = (p % 3 == 1) || (p == 6);
            rx_fast = (p % 3 == 2) || (p == 6);
            if (p == 0) begin
                // invalid before sync, sync lifts the stop, second wide pulse is a float bit,
                // range edges, overlap, width between long and float stops decoding
                send_pulse(16'd100, 1'b0);
                send_pulse(16'd300, 1'b0);
                send_pulse(16'd4000, 1'b0);
                send_pulse(16'd5000, 1'b0);
                send_pulse(16'd200, 1'b0);
                send_pulse(16'd720, 1'b0);
                send_pulse(16'd650, 1'b0);
                send_pulse(16'd721, 1'b0);
                send_pulse(16'd2160, 1'b0);
                send_pulse(16'd2800, 1'b0);
                send_pulse(16'd300, 1'b0);
                send_pulse(16'd300, 1'b0);
                send_pulse(16'd300, 1'b0);
                send_pulse(16'hFFFF, 1'b1);
                send_pulse(16'd0, 1'b0);
                send_pulse(16'hFFFF, 1'b0);
                send_pulse(16'hFFFF, 1'b0);
                send_pulse(16'd2801, 1'b0);
                send_pulse(16'd300, 1'b0);
                send_pulse(16'd1000, 1'b0);
                send_pulse(16'd2161, 1'b0);
                send_pulse(16'd300, 1'b1);
                send_pulse(16'd4000, 1'b1);

                // hold the result side while single-pulse packets keep coming
                rx_hold_req = 1'b1;
                for (int i = 0; i < 40; i++) send_pulse(pick_width(PK_ANY), 1'b1);
                wait_drained();
            end
            phase_end = pulses_sent + PHASE_PULSES;
            while (pulses_sent < phase_end) send_burst();
        end

        wait_drained();
        repeat (20) @(posedge aclk);
        if (mismatch_count == 0 && pending == 0) begin
            $display("pwm_pulse_width_decoder_unit: match");
        end else begin
            $display("pwm_pulse_width_decoder_unit: mismatch");
        end
        $finish;
    end

endmodule
